[rtl/core/csx_pkg.sv]
// Shared types, constants and block functions for the ChaCha20 byte stream XOR block.
// No dependencies; every file of the block but the two channel interfaces and the checker imports it.
package csx_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_0_7   = 3'd0,
    REG_KEY_8_15  = 3'd1,
    REG_KEY_16_23 = 3'd2,
    REG_KEY_24_31 = 3'd3,
    REG_NONCE_0_7 = 3'd4,
    REG_NONCE_8_11 = 3'd5,
    REG_START_CTR = 3'd6
  } csx_reg_e;

  // The four constant words of the initial state, word 0 in the low slot
  localparam logic [3:0][31:0] SIGMA = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  // Rotation amounts of the quarter round
  localparam int unsigned ROT_A = 16;
  localparam int unsigned ROT_B = 12;
  localparam int unsigned ROT_C = 8;
  localparam int unsigned ROT_D = 7;

  // Word indexes of the four quarter rounds: [lane][a,b,c,d]
  localparam logic [3:0][3:0][3:0] COL_IDX = {
    {4'd15, 4'd11, 4'd7, 4'd3},
    {4'd14, 4'd10, 4'd6, 4'd2},
    {4'd13, 4'd9,  4'd5, 4'd1},
    {4'd12, 4'd8,  4'd4, 4'd0}
  };
  localparam logic [3:0][3:0][3:0] DIAG_IDX = {
    {4'd14, 4'd9,  4'd4, 4'd3},
    {4'd13, 4'd8,  4'd7, 4'd2},
    {4'd12, 4'd11, 4'd6, 4'd1},
    {4'd15, 4'd10, 4'd5, 4'd0}
  };

  // One keystream block, sixteen words
  typedef logic [15:0][31:0] csx_block_t;

  // Key, nonce and start counter as held by the configuration registers
  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
    logic [31:0]      start_ctr;
  } csx_cfg_t;

  // One classified byte travelling from the front to the back
  typedef struct packed {
    logic [7:0]  data;
    logic        final_flag;
    logic [5:0]  pos;
    logic        new_blk;
    logic [31:0] ctr;
  } csx_item_t;

  function automatic logic [31:0] csx_rotl(input logic [31:0] v, input int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // First half of a quarter round: a += b; d ^= a; d <<<= 16; c += d; b ^= c; b <<<= 12
  function automatic logic [3:0][31:0] csx_qr_first(input logic [3:0][31:0] v);
    logic [31:0] a, b, c, d;
    a = v[0] + v[1];
    d = csx_rotl(v[3] ^ a, ROT_A);
    c = v[2] + d;
    b = csx_rotl(v[1] ^ c, ROT_B);
    return {d, c, b, a};
  endfunction

  // Second half of a quarter round with the rotations by 8 and 7
  function automatic logic [3:0][31:0] csx_qr_second(input logic [3:0][31:0] v);
    logic [31:0] a, b, c, d;
    a = v[0] + v[1];
    d = csx_rotl(v[3] ^ a, ROT_C);
    c = v[2] + d;
    b = csx_rotl(v[1] ^ c, ROT_D);
    return {d, c, b, a};
  endfunction

  // Initial state of a block from the configuration and a block counter
  function automatic csx_block_t csx_init_state(input csx_cfg_t cfg, input logic [31:0] ctr);
    csx_block_t s;
    for (int i = 0; i < 4; i++) begin
      s[i] = SIGMA[i];
    end
    for (int i = 0; i < 8; i++) begin
      s[4 + i] = cfg.key[i];
    end
    s[12] = ctr;
    for (int i = 0; i < 3; i++) begin
      s[13 + i] = cfg.nonce[i];
    end
    return s;
  endfunction

endpackage

[rtl/core/csx_in_if.sv]
// Input channel of the ChaCha20 byte stream XOR block: valid/ready and one byte with flags.
// No dependencies.
interface csx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_in;
  logic       first_of_message;
  logic       final_of_message;

  modport source (output valid, data_in, first_of_message, final_of_message, input ready);
  modport sink   (input valid, data_in, first_of_message, final_of_message, output ready);
endinterface

[rtl/core/csx_out_if.sv]
// Output channel of the ChaCha20 byte stream XOR block: valid/ready and one result byte.
// No dependencies.
interface csx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       final_out;

  modport source (output valid, data_out, final_out, input ready);
  modport sink   (input valid, data_out, final_out, output ready);
endinterface

[rtl/core/chacha20_stream_xor_top.sv]
// ChaCha20 byte stream XOR block, top level: configuration registers, front end, queue, back end.
// Depends on csx_pkg, csx_in_if, csx_out_if and the csx_cfg_regs, csx_front, csx_fifo, csx_back and csx_core modules.
//
// Usage: write key, nonce and start counter through the configuration port (index 0..6)
// while the block is idle. Bytes enter on in_i with a first-of-message flag that restarts
// the keystream at the start counter; each result on out_o is the byte XOR the keystream
// byte, with the final flag copied through. Both channels transfer on valid and ready high.
// A byte inside a block passes through the queue and then the output register. A byte that opens a
// block whose keystream is not prefetched also waits for the block function unit, which runs
// half a quarter round per lane each cycle.
// Throughput: one byte per cycle sustained while the receiver keeps ready high; the next block
// is prefetched while the current 64 bytes stream, so only the first block of a message or a
// restart stalls.
// Reset clears the counters, the queue and the configuration; the stream then starts at
// counter zero. When the receiver stalls, the result waits in the output register, the queue
// of QUEUE_DEPTH bytes fills, and in_i.ready drops only when the queue is full.
module chacha20_stream_xor_top
  import csx_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  csx_in_if.sink                in_i,
  csx_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  csx_cfg_t  cfg;
  csx_item_t push_item, head_item;
  logic      push, queue_full, head_valid, pop;

  // Configuration
  csx_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Byte classification
  csx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_data_i    (in_i.data_in),
    .in_first_i   (in_i.first_of_message),
    .in_final_i   (in_i.final_of_message),
    .in_ready_o   (in_i.ready),
    .start_ctr_i  (cfg.start_ctr),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (push_item)
  );

  // Queue between the two halves
  csx_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (queue_full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .head_o  (head_item)
  );

  // Keystream generation and XOR
  csx_back #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cfg_we_i     (cfg_we_i),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_data_o   (out_o.data_out),
    .out_final_o  (out_o.final_out)
  );

endmodule

[rtl/core/csx_cfg_regs.sv]
// Configuration registers: key, nonce and start counter behind a plain write port.
// Depends on csx_pkg.
module csx_cfg_regs
  import csx_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output csx_cfg_t              cfg_o
);

  csx_cfg_t cfg_q, cfg_d;

  // Decode the register index; unknown indexes leave everything unchanged.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_0_7: begin
          cfg_d.key[0] = cfg_wdata_i[31:0];
          cfg_d.key[1] = cfg_wdata_i[63:32];
        end
        REG_KEY_8_15: begin
          cfg_d.key[2] = cfg_wdata_i[31:0];
          cfg_d.key[3] = cfg_wdata_i[63:32];
        end
        REG_KEY_16_23: begin
          cfg_d.key[4] = cfg_wdata_i[31:0];
          cfg_d.key[5] = cfg_wdata_i[63:32];
        end
        REG_KEY_24_31: begin
          cfg_d.key[6] = cfg_wdata_i[31:0];
          cfg_d.key[7] = cfg_wdata_i[63:32];
        end
        REG_NONCE_0_7: begin
          cfg_d.nonce[0] = cfg_wdata_i[31:0];
          cfg_d.nonce[1] = cfg_wdata_i[63:32];
        end
        REG_NONCE_8_11: begin
          cfg_d.nonce[2] = cfg_wdata_i[31:0];
        end
        REG_START_CTR: begin
          cfg_d.start_ctr = cfg_wdata_i[31:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/csx_front.sv]
// Front end: accepts input bytes, tracks byte position and block counter, and tags each byte.
// Depends on csx_pkg.
module csx_front
  import csx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_first_i,
  input  logic        in_final_i,
  output logic        in_ready_o,
  input  logic [31:0] start_ctr_i,
  input  logic        queue_full_i,
  output logic        push_o,
  output csx_item_t   item_o
);

  logic [5:0]  pos_q, pos_d, pos_eff;
  logic [31:0] ctr_q, ctr_d, ctr_eff;
  logic        new_blk;

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // A first flag restarts at the start counter and position zero.
  assign pos_eff = in_first_i ? 6'd0 : pos_q;
  assign ctr_eff = in_first_i ? start_ctr_i : ctr_q;
  assign new_blk = (pos_eff == 6'd0);

  always_comb begin
    item_o.data       = in_data_i;
    item_o.final_flag = in_final_i;
    item_o.pos        = pos_eff;
    item_o.new_blk    = new_blk;
    item_o.ctr        = ctr_eff;
  end

  // Position wraps every 64 bytes; the counter moves on when a block is opened.
  always_comb begin
    pos_d = pos_q;
    ctr_d = ctr_q;
    if (push_o) begin
      pos_d = pos_eff + 6'd1;
      ctr_d = new_blk ? ctr_eff + 32'd1 : ctr_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      ctr_q <= '0;
    end else begin
      pos_q <= pos_d;
      ctr_q <= ctr_d;
    end
  end

endmodule

[rtl/core/csx_fifo.sv]
// Short queue of tagged bytes between the front end and the back end.
// Depends on csx_pkg.
module csx_fifo
  import csx_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  csx_item_t item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output csx_item_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  csx_item_t        mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/core/csx_core.sv]
// Block function unit: builds one keystream block, half a quarter round per lane each cycle.
// Depends on csx_pkg.
module csx_core
  import csx_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  csx_cfg_t    cfg_i,
  input  logic        start_i,
  input  logic        abort_i,
  input  logic [31:0] ctr_i,
  output logic        busy_o,
  output logic        done_o,
  output logic [31:0] ctr_o,
  output csx_block_t  block_o
);

  localparam int unsigned STEPS  = 4 * DOUBLE_ROUNDS;
  localparam int unsigned STEP_W = $clog2(STEPS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FINAL = 3'b100
  } core_state_e;

  core_state_e           state_q, state_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  done_q, done_d;
  logic [31:0]           ctr_q;
  csx_block_t            work_q, round_w, final_w, init_w;
  logic [3:0][3:0][3:0]  lane_idx;
  logic [3:0][3:0][31:0] lane_in, lane_out;
  logic                  half, diag;

  // Step bit 0 picks the half of the quarter round, bit 1 column or diagonal.
  assign half     = step_q[0];
  assign diag     = step_q[1];
  assign lane_idx = diag ? DIAG_IDX : COL_IDX;

  // Four quarter-round lanes working side by side
  always_comb begin
    round_w  = work_q;
    lane_in  = '0;
    lane_out = '0;
    for (int l = 0; l < 4; l++) begin
      for (int k = 0; k < 4; k++) begin
        lane_in[l][k] = work_q[lane_idx[l][k]];
      end
      lane_out[l] = half ? csx_qr_second(lane_in[l]) : csx_qr_first(lane_in[l]);
      for (int k = 0; k < 4; k++) begin
        round_w[lane_idx[l][k]] = lane_out[l][k];
      end
    end
  end

  // Feed-forward of the initial state after the last round
  assign init_w = csx_init_state(cfg_i, ctr_q);
  always_comb begin
    for (int w = 0; w < 16; w++) begin
      final_w[w] = work_q[w] + init_w[w];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
      end
      ST_ROUND: begin
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(STEPS - 1)) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        state_d = ST_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (abort_i) begin
      state_d = ST_IDLE;
      done_d  = 1'b0;
    end else if (start_i) begin
      state_d = ST_ROUND;
      step_d  = '0;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  // Working state and the counter of the block under way
  always_ff @(posedge clk_i) begin
    if (start_i && !abort_i) begin
      work_q <= csx_init_state(cfg_i, ctr_i);
      ctr_q  <= ctr_i;
    end else if (state_q == ST_ROUND) begin
      work_q <= round_w;
    end else if (state_q == ST_FINAL) begin
      work_q <= final_w;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign done_o  = done_q;
  assign ctr_o   = ctr_q;
  assign block_o = work_q;

endmodule

[rtl/core/csx_back.sv]
// Back end: keeps the current and the prefetched keystream block, XORs bytes, drives results.
// Depends on csx_pkg and csx_core.
module csx_back
  import csx_pkg::*;
#(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  csx_cfg_t   cfg_i,
  input  logic       cfg_we_i,
  input  logic       head_valid_i,
  input  csx_item_t  head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_data_o,
  output logic       out_final_o
);

  csx_block_t  cur_blk_q, next_blk_q, core_blk, src_blk;
  logic        next_valid_q;
  logic [31:0] next_ctr_q, core_ctr, core_ctr_in, ks_word;
  logic        core_busy, core_done, core_start;
  logic        can_out, hit, pending;
  logic [7:0]  ks_byte;
  logic        out_valid_q;
  logic [7:0]  out_data_q;
  logic        out_final_q;

  csx_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_i),
    .start_i (core_start),
    .abort_i (cfg_we_i),
    .ctr_i   (core_ctr_in),
    .busy_o  (core_busy),
    .done_o  (core_done),
    .ctr_o   (core_ctr),
    .block_o (core_blk)
  );

  // A byte opening a block needs the prefetched block with its counter.
  assign can_out = !out_valid_q || out_ready_i;
  assign hit     = next_valid_q && (next_ctr_q == head_i.ctr);
  assign pending = (core_busy || core_done) && (core_ctr == head_i.ctr);
  assign pop_o   = head_valid_i && can_out && (!head_i.new_blk || hit);

  // On a hit the next counter is prefetched; on a miss the needed block is started unless already under way.
  assign core_start  = head_valid_i && head_i.new_blk && !cfg_we_i &&
                       ((hit && can_out) || (!hit && !pending));
  assign core_ctr_in = hit ? head_i.ctr + 32'd1 : head_i.ctr;

  // Keystream byte, little-endian within each word
  assign src_blk = head_i.new_blk ? next_blk_q : cur_blk_q;
  assign ks_word = src_blk[head_i.pos[5:2]];
  assign ks_byte = ks_word[8 * head_i.pos[1:0] +: 8];

  // Block slots
  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.new_blk) begin
      cur_blk_q <= next_blk_q;
    end
    if (core_done) begin
      next_blk_q <= core_blk;
      next_ctr_q <= core_ctr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_valid_q <= 1'b0;
    end else if (cfg_we_i || core_start) begin
      next_valid_q <= 1'b0;
    end else if (core_done) begin
      next_valid_q <= 1'b1;
    end
  end

  // Output register: takes a new result whenever the last one is gone or is being taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (can_out) begin
      out_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q  <= head_i.data ^ ks_byte;
      out_final_q <= head_i.final_flag;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_final_o = out_final_q;

endmodule

[rtl/core/csx_checker.sv]
// Port-level checker for the ChaCha20 byte stream XOR block, bound to the top level.
// Depends on chacha20_stream_xor_top and its channel interfaces.
module csx_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_data_i,
  input logic       out_final_i
);

  logic [7:0] inflight_q;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  // Bytes accepted whose results have not yet been transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_q <= inflight_q + 8'd1;
    end else if (out_xfer && !in_xfer) begin
      inflight_q <= inflight_q - 8'd1;
    end
  end

  // A result needs a byte accepted on an earlier edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (inflight_q != 8'd0))
    else $error("result transferred with no byte outstanding");

  // Reset leaves no result pending.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("output valid dropped while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> ($stable(out_data_i) && $stable(out_final_i)))
    else $error("output payload changed while stalled");

endmodule

bind chacha20_stream_xor_top csx_checker u_csx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data_out),
  .out_final_i (out_o.final_out)
);

[tb/csx_tb_pkg.sv]
`timescale 1ns / 100ps
// Scoreboard for the ChaCha20 byte stream XOR testbench: keystream predictor and result checks.
// Depends on csx_pkg for the register indexes and the configuration port widths.
package csx_tb_pkg;
  import csx_pkg::*;

  // Number of double rounds the block under test is built with
  localparam int unsigned TB_DOUBLE_ROUNDS = 10;
  // Mismatches beyond this many are counted but not printed
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       final_flag;
  } xor_result_t;

  class csx_xor_checker;
    // Configuration as last written through the register port
    logic [31:0] key_w [8];
    logic [31:0] nonce_w [3];
    logic [31:0] start_ctr;
    // Keystream position of the stream
    logic [31:0] blk_ctr;
    logic [5:0]  byte_pos;
    logic [31:0] ks_words [16];
    logic [31:0] mix_w [16];
    // Results still owed by the block, oldest first
    xor_result_t expected_bytes [$];
    int unsigned error_count;

    function new();
      foreach (key_w[i]) key_w[i] = '0;
      foreach (nonce_w[i]) nonce_w[i] = '0;
      foreach (ks_words[i]) ks_words[i] = '0;
      start_ctr   = '0;
      blk_ctr     = '0;
      byte_pos    = '0;
      error_count = 0;
    endfunction

    // Mirror of one register write; indexes outside the map are dropped.
    function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_KEY_0_7: begin
          key_w[0] = val[31:0];
          key_w[1] = val[63:32];
        end
        REG_KEY_8_15: begin
          key_w[2] = val[31:0];
          key_w[3] = val[63:32];
        end
        REG_KEY_16_23: begin
          key_w[4] = val[31:0];
          key_w[5] = val[63:32];
        end
        REG_KEY_24_31: begin
          key_w[6] = val[31:0];
          key_w[7] = val[63:32];
        end
        REG_NONCE_0_7: begin
          nonce_w[0] = val[31:0];
          nonce_w[1] = val[63:32];
        end
        REG_NONCE_8_11: nonce_w[2] = val[31:0];
        REG_START_CTR:  start_ctr = val[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] rotl32(logic [31:0] v, int unsigned n);
      logic [63:0] twice;
      twice = {v, v} << n;
      return twice[63:32];
    endfunction

    // One quarter round on the working words
    function void quarter_mix(int a, int b, int c, int d);
      mix_w[a] += mix_w[b];
      mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 16);
      mix_w[c] += mix_w[d];
      mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 12);
      mix_w[a] += mix_w[b];
      mix_w[d] = rotl32(mix_w[d] ^ mix_w[a], 8);
      mix_w[c] += mix_w[d];
      mix_w[b] = rotl32(mix_w[b] ^ mix_w[c], 7);
    endfunction

    // Builds the 64-byte keystream block for a given block counter.
    function void build_keystream(logic [31:0] ctr);
      logic [31:0] init_w [16];
      init_w[0] = 32'h61707865;
      init_w[1] = 32'h3320646e;
      init_w[2] = 32'h79622d32;
      init_w[3] = 32'h6b206574;
      for (int i = 0; i < 8; i++) init_w[4 + i] = key_w[i];
      init_w[12] = ctr;
      for (int i = 0; i < 3; i++) init_w[13 + i] = nonce_w[i];
      mix_w = init_w;
      for (int r = 0; r < TB_DOUBLE_ROUNDS; r++) begin
        quarter_mix(0, 4, 8, 12);
        quarter_mix(1, 5, 9, 13);
        quarter_mix(2, 6, 10, 14);
        quarter_mix(3, 7, 11, 15);
        quarter_mix(0, 5, 10, 15);
        quarter_mix(1, 6, 11, 12);
        quarter_mix(2, 7, 8, 13);
        quarter_mix(3, 4, 9, 14);
      end
      for (int i = 0; i < 16; i++) ks_words[i] = mix_w[i] + init_w[i];
    endfunction

    // Notes an accepted input byte and queues the result it must produce.
    function void predict_byte(logic [7:0] data, logic first, logic fin);
      logic [31:0] word;
      logic [7:0]  ks;
      if (first) begin
        blk_ctr  = start_ctr;
        byte_pos = '0;
      end
      if (byte_pos == 6'd0) begin
        build_keystream(blk_ctr);
        blk_ctr += 32'd1;
      end
      word = ks_words[byte_pos[5:2]];
      ks   = word[byte_pos[1:0] * 8 +: 8];
      expected_bytes.push_back('{data: data ^ ks, final_flag: fin});
      byte_pos += 6'd1;
    endfunction

    // Compares an accepted result with the oldest outstanding one.
    function void check_byte(logic [7:0] data, logic fin);
      xor_result_t want;
      if (expected_bytes.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: result data %h final %b arrived with none outstanding",
                   $time, data, fin);
        end
        return;
      end
      want = expected_bytes.pop_front();
      if (want.data !== data || want.final_flag !== fin) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: mismatch: expected data %h final %b, got data %h final %b",
                   $time, want.data, want.final_flag, data, fin);
        end
      end
    endfunction
  endclass

endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top level of the ChaCha20 byte stream XOR testbench: clock, reset, stimulus and result sink.
// Depends on csx_pkg, csx_tb_pkg, the csx_in_if and csx_out_if interfaces and the RTL.
module tb_top;
  import csx_pkg::*;
  import csx_tb_pkg::*;

  // Register index with no register behind it; writes to it must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_IDX_SPARE = 3'd7;
  localparam int unsigned IDLE_PCT        = 22;
  localparam int unsigned N_PHASES        = 8;
  localparam int unsigned ITEMS_PER_PHASE = 95;
  localparam int unsigned PHASE_ALL_ONES  = 1;
  localparam int unsigned PHASE_ALL_ZEROS = 2;
  localparam int unsigned QUIET_PHASE     = 5;
  localparam int unsigned SETTLE_CYCLES   = 4 * TB_DOUBLE_ROUNDS + 16;

  typedef enum int unsigned {
    MSG_FULL,   // first flag on the opening byte, final flag on the closing byte
    MSG_TAIL,   // carries on the running keystream, final flag at the end
    MSG_NOISE   // flags at random
  } msg_kind_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  bit                    idle_on;
  int unsigned           phase_items;
  csx_xor_checker        xor_sb;

  csx_in_if  in_ch ();
  csx_out_if out_ch ();

  chacha20_stream_xor_top #(
    .DOUBLE_ROUNDS(TB_DOUBLE_ROUNDS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Result sink: check every transfer, then, while idle cycles are on, stall at random for the next edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        xor_sb.check_byte(out_ch.data_out, out_ch.final_out);
      end
      out_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Offers one byte, with random idle cycles first while idle cycles are on, and returns at its transfer.
  task automatic send_byte(input logic [7:0] d, input logic first, input logic fin);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid            <= 1'b1;
    in_ch.data_in          <= d;
    in_ch.first_of_message <= first;
    in_ch.final_of_message <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    xor_sb.predict_byte(d, first, fin);
    phase_items++;
  endtask

  task automatic send_message(input int unsigned len, input msg_kind_e kind);
    for (int unsigned i = 0; i < len; i++) begin
      case (kind)
        MSG_FULL:  send_byte(8'($urandom_range(255)), i == 0, i == len - 1);
        MSG_TAIL:  send_byte(8'($urandom_range(255)), 1'b0, i == len - 1);
        default:   send_byte(8'($urandom_range(255)), $urandom_range(7) == 0,
                             $urandom_range(3) == 0);
      endcase
    end
  endtask

  // Stops offering bytes and waits until every result is in and the block is quiet.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (xor_sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes every register for a phase: all ones, all zeros, or random values; at times also the spare index.
  task automatic load_registers(input int unsigned phase);
    logic [CFG_DATA_W-1:0] val;
    for (int r = REG_KEY_0_7; r <= REG_START_CTR; r++) begin
      case (phase)
        PHASE_ALL_ONES:  val = '1;
        PHASE_ALL_ZEROS: val = '0;
        default:         val = {$urandom, $urandom};
      endcase
      // Start the counter close to its wrap now and then.
      if (r == REG_START_CTR && phase > PHASE_ALL_ZEROS && $urandom_range(2) == 0) begin
        val[31:0] = 32'hFFFF_FFFF - $urandom_range(2);
      end
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(r);
      cfg_wdata <= val;
      @(posedge clk_i);
      xor_sb.apply_reg_write(CFG_IDX_W'(r), val);
    end
    if (phase == PHASE_ALL_ZEROS || $urandom_range(1) == 0) begin
      val       = {$urandom, $urandom};
      cfg_idx   <= REG_IDX_SPARE;
      cfg_wdata <= val;
      @(posedge clk_i);
      xor_sb.apply_reg_write(REG_IDX_SPARE, val);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned kind;
    int unsigned len;
    xor_sb                 = new();
    rst_ni                 = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = '0;
    cfg_wdata              = '0;
    in_ch.valid            = 1'b0;
    in_ch.data_in          = '0;
    in_ch.first_of_message = 1'b0;
    in_ch.final_of_message = 1'b0;
    idle_on                = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed bytes on the reset configuration. The stream opens without a first
    // flag, so it must start at counter zero.
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    // A final flag resets nothing: the next byte continues the keystream.
    send_byte(8'hAA, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
    // Restart in the middle of a block, then two one-byte messages and a two-byte message.
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h0F, 1'b1, 1'b1);
    send_byte(8'hF0, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b1);

    // Random phases, each on a fresh configuration and opened by a first flag.
    for (int unsigned p = 1; p <= N_PHASES; p++) begin
      wait_drained();
      load_registers(p);
      idle_on     = (p != QUIET_PHASE);
      phase_items = 0;
      // With the counter at all ones the first message runs over the wrap.
      send_message((p == PHASE_ALL_ONES) ? 130 : $urandom_range(1, 70), MSG_FULL);
      while (phase_items < ITEMS_PER_PHASE) begin
        kind = $urandom_range(99);
        if (kind < 75) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(65, 160) : $urandom_range(1, 64);
          send_message(len, MSG_FULL);
        end else if (kind < 88) begin
          send_message($urandom_range(1, 40), MSG_TAIL);
        end else begin
          send_message($urandom_range(1, 20), MSG_NOISE);
        end
      end
    end

    wait_drained();
    if (xor_sb.error_count == 0 && xor_sb.expected_bytes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/csx_pkg.sv
rtl/core/csx_in_if.sv
rtl/core/csx_out_if.sv
rtl/core/csx_cfg_regs.sv
rtl/core/csx_front.sv
rtl/core/csx_fifo.sv
rtl/core/csx_core.sv
rtl/core/csx_back.sv
rtl/core/chacha20_stream_xor_top.sv
rtl/core/csx_checker.sv
tb/csx_tb_pkg.sv
tb/tb_top.sv
